// ===== design/iaq_pkg.sv =====
// shared widths, command and status codes and cell control type for the indexed array list
package iaq_pkg;

   localparam int WORD_W   = 32;
   localparam int CMD_W    = 3;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic write_at;
      logic insert_at;
      logic remove_at;
   } iaq_ctrl_type;

endpackage

// ===== design/iaq_cell.sv =====
// one storage cell of the list: holds a word and shifts with its neighbours
module iaq_cell
   import iaq_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  iaq_ctrl_type             ctrl,
   input  logic [IDX_W-1:0]         target,
   input  logic signed [WORD_W-1:0] word,
   input  logic signed [WORD_W-1:0] left_word,
   input  logic signed [WORD_W-1:0] right_word,
   output logic signed [WORD_W-1:0] data,
   output logic signed [WORD_W-1:0] tap
);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;
   logic                     at;
   logic                     above;

   assign at    = (target == IDX_W'(INDEX));
   assign above = (target < IDX_W'(INDEX));

   always_comb begin
      data_in = data_ff;
      if (ctrl.write_at && at) begin
         data_in = word;
      end
      if (ctrl.insert_at) begin
         if (at) begin
            data_in = word;
         end else if (above) begin
            data_in = left_word;
         end
      end
      if (ctrl.remove_at && (at || above)) begin
         data_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = at ? data_ff : '0;

endmodule

// ===== design/indexed_array_list.sv =====
// top level of the indexed array list: command register, cell chain and result register
// a command is held in the command register while it executes, then its result goes to the result register
// throughput: one command per cycle, busy stays low; shifts happen in all cells at once
// the read path is an or-combine of one tap per cell in the execute cycle
// reset clears the length and the strobes; cell contents stay undefined until written
// the receiver cannot stall: each result is shown for exactly one cycle
module indexed_array_list
   import iaq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [WORD_W-1:0]   req_word_in,
   output logic                       rsp_valid,
   output logic signed [WORD_W-1:0]   rsp_word_out,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [LEN_W-1:0]           rsp_length
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic                     stage_valid_ff;
   logic [CMD_W-1:0]         cmd_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [WORD_W-1:0] word_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;

   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_word_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [LEN_W-1:0]         rsp_length_ff;

   logic signed [WORD_W-1:0] word_out;
   logic [STATUS_W-1:0]      status;
   logic                     in_range;
   logic                     full;
   logic signed [WORD_W-1:0] rd_word;
   iaq_ctrl_type             ctrl;
   logic [IDX_W-1:0]         target;

   logic signed [WORD_W-1:0] cell_data [CAPACITY];
   logic signed [WORD_W-1:0] cell_tap  [CAPACITY];

   assign busy     = 1'b0;
   assign in_range = CMP_W'(pos_ff) < CMP_W'(count_ff);
   assign full     = (CMP_W'(count_ff) >= CMP_W'(CAPACITY));

   // read tap combine
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | cell_tap[i];
      end
   end

   always_comb begin
      ctrl     = '0;
      word_out = '0;
      status   = ST_OK;
      count_in = count_ff;
      target   = IDX_W'(pos_ff);
      if (stage_valid_ff) begin
         case (cmd_ff)
            CMD_READ: begin
               if (in_range) begin
                  word_out = rd_word;
               end else begin
                  status = ST_RANGE;
               end
            end
            CMD_WRITE: begin
               if (in_range) begin
                  ctrl.write_at = 1'b1;
               end else begin
                  status = ST_RANGE;
               end
            end
            CMD_APPEND: begin
               target = IDX_W'(count_ff);
               if (full) begin
                  status = ST_FULL;
               end else begin
                  ctrl.write_at = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            CMD_INSERT: begin
               if (!in_range) begin
                  status = ST_RANGE;
               end else if (full) begin
                  status = ST_FULL;
               end else begin
                  ctrl.insert_at = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (in_range) begin
                  word_out       = rd_word;
                  ctrl.remove_at = 1'b1;
                  count_in       = count_ff - CNT_W'(1);
               end else begin
                  status = ST_RANGE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [WORD_W-1:0] left_word;
      logic signed [WORD_W-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_l
         assign left_word = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_r
         assign right_word = cell_data[g+1];
      end

      iaq_cell #(
         .IDX_W (IDX_W),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .target     (target),
         .word       (word_ff),
         .left_word  (left_word),
         .right_word (right_word),
         .data       (cell_data[g]),
         .tap        (cell_tap[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= start && !busy;
         rsp_valid_ff   <= stage_valid_ff;
         count_ff       <= count_in;
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      cmd_ff        <= req_command;
      pos_ff        <= req_position;
      word_ff       <= req_word_in;
      rsp_word_ff   <= word_out;
      rsp_status_ff <= status;
      rsp_length_ff <= LEN_W'(count_in);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_length   = rsp_length_ff;

endmodule
